@@ hw/rtl/hte_pkg.sv @@
package hte_pkg;

   // Field widths of the request and response items
   localparam int SYM_W      = 8;
   localparam int CODE_W     = 32;
   localparam int LEN_W      = 6;
   localparam int OPCODE_W   = 2;
   localparam int BYTE_BITS  = 8;
   localparam int REQ_DATA_W = ((SYM_W + CODE_W + LEN_W + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;

   // Code table
   localparam int MAX_CODE_LEN = 32;
   localparam int TABLE_DEPTH  = 256;
   localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
   localparam int STORED_LEN_W = $clog2(MAX_CODE_LEN + 1);
   localparam int CODE_EXT_W   = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

   // Packer accumulator: up to 7 pending bits plus one full code
   localparam int ACC_W = MAX_CODE_LEN + BYTE_BITS;
   localparam int CNT_W = $clog2(ACC_W + 1);

   // Command queue between front and packer
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } opcode_type;

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_FLUSH  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      logic [STORED_LEN_W-1:0] len;
      logic [MAX_CODE_LEN-1:0] bits;
   } entry_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [STORED_LEN_W-1:0] len;
      logic [MAX_CODE_LEN-1:0] bits;
   } cmd_type;

endpackage

@@ hw/rtl/hte_ram.sv @@
module hte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/hte_front.sv @@
module hte_front import hte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OPCODE_W-1:0]   req_tuser,
   output logic                  push_valid,
   output cmd_type               push_cmd,
   input  logic                  push_ready
);

   logic [SYM_W-1:0]  sym;
   logic [CODE_W-1:0] code_value;
   logic [LEN_W-1:0]  code_length;
   opcode_type        opcode;
   logic              accept;

   logic [STORED_LEN_W-1:0] load_len;
   logic [CODE_EXT_W-1:0]   code_ext;
   logic [MAX_CODE_LEN-1:0] load_mask;
   entry_type               wr_entry;
   logic                    wr_en;
   logic                    rd_en;
   entry_type               rd_entry;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   s2_valid_ff, s2_valid_in;
   cmd_kind_type           s2_kind_ff, s2_kind_in;
   logic                   s2_hit_ff, s2_hit_in;
   logic                   s2_need;
   logic                   s2_done;

   assign sym         = req_tdata[SYM_W-1:0];
   assign code_value  = req_tdata[SYM_W +: CODE_W];
   assign code_length = req_tdata[SYM_W + CODE_W +: LEN_W];
   assign opcode      = opcode_type'(req_tuser);

   // Clamp overlong lengths and drop code bits above the length
   always_comb begin
      if (code_length > LEN_W'(MAX_CODE_LEN)) begin
         load_len = STORED_LEN_W'(MAX_CODE_LEN);
      end else begin
         load_len = STORED_LEN_W'(code_length);
      end
      code_ext = CODE_EXT_W'(code_value);
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
         load_mask[i] = (i < int'(load_len));
      end
      wr_entry.len  = load_len;
      wr_entry.bits = code_ext[MAX_CODE_LEN-1:0] & load_mask;
   end

   assign req_tready = !s2_valid_ff || s2_done;
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && (opcode == OP_LOAD);
   assign rd_en      = accept && (opcode == OP_ENCODE);

   hte_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sym),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (sym),
      .rd_data (rd_entry)
   );

   // Stage 2: lookup result, pushed to the queue if it does anything
   always_comb begin
      push_cmd.kind = s2_kind_ff;
      if (s2_kind_ff == CMD_ENCODE && s2_hit_ff) begin
         push_cmd.len  = rd_entry.len;
         push_cmd.bits = rd_entry.bits;
      end else begin
         push_cmd.len  = '0;
         push_cmd.bits = '0;
      end
      s2_need    = (s2_kind_ff == CMD_FLUSH) || (push_cmd.len != '0);
      push_valid = s2_valid_ff && s2_need;
      s2_done    = s2_valid_ff && (!s2_need || push_ready);
   end

   always_comb begin
      valid_in    = valid_ff;
      s2_valid_in = s2_valid_ff && !s2_done;
      s2_kind_in  = s2_kind_ff;
      s2_hit_in   = s2_hit_ff;
      if (accept) begin
         unique case (opcode)
            OP_LOAD: begin
               valid_in[sym] = 1'b1;
            end
            OP_ENCODE: begin
               s2_valid_in = 1'b1;
               s2_kind_in  = CMD_ENCODE;
               s2_hit_in   = valid_ff[sym];
            end
            OP_FLUSH: begin
               s2_valid_in = 1'b1;
               s2_kind_in  = CMD_FLUSH;
               s2_hit_in   = 1'b0;
            end
            default: begin
               // unused opcode: dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s2_kind_ff <= s2_kind_in;
      s2_hit_ff  <= s2_hit_in;
   end

endmodule

@@ hw/rtl/hte_queue.sv @@
module hte_queue import hte_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hw/rtl/hte_packer.sv @@
module hte_packer import hte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  cmd_type              cmd,
   output logic                 cmd_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BYTE_BITS-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   // Bits are kept left-aligned: the next output byte is the top byte.
   logic [ACC_W-1:0]     buf_ff, buf_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0] rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 out_free;
   logic                 emit;
   logic [ACC_W-1:0]     code_aligned;
   logic [CNT_W-1:0]     align_shift;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      align_shift  = CNT_W'(ACC_W) - CNT_W'(cmd.len);
      code_aligned = (ACC_W'(cmd.bits) << align_shift) >> cnt_ff;
   end

   always_comb begin
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      cmd_pop     = 1'b0;
      emit        = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      priority if (cnt_ff >= CNT_W'(BYTE_BITS)) begin
         if (out_free) begin
            emit        = 1'b1;
            rsp_byte_in = buf_ff[ACC_W-1 -: BYTE_BITS];
            rsp_last_in = (cnt_ff < CNT_W'(2 * BYTE_BITS));
            buf_in      = buf_ff << BYTE_BITS;
            cnt_in      = cnt_ff - CNT_W'(BYTE_BITS);
         end
      end else if (cmd_valid && cmd.kind == CMD_ENCODE) begin
         cmd_pop = 1'b1;
         buf_in  = buf_ff | code_aligned;
         cnt_in  = cnt_ff + CNT_W'(cmd.len);
      end else if (cmd_valid && cnt_ff == '0) begin
         // flush with nothing pending
         cmd_pop = 1'b1;
      end else if (cmd_valid && out_free) begin
         cmd_pop     = 1'b1;
         emit        = 1'b1;
         rsp_byte_in = buf_ff[ACC_W-1 -: BYTE_BITS];
         rsp_last_in = 1'b1;
         buf_in      = '0;
         cnt_in      = '0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ hw/rtl/huffman_table_encoder_packer.sv @@
// Channel  Dir  Ports                     Contents
// req      in   req_tvalid/tready/tdata   tdata: symbol, code_value, code_length
//                req_tuser                 tuser: opcode (load/encode/flush)
// rsp      out  rsp_tvalid/tready/tdata   tdata: out_byte
//                rsp_tlast                 tlast: last byte caused by a request
//
// A request is taken every cycle while the command queue has room; loads finish
// in the front and never reach the queue. The packer merges an encode's code and
// then emits the full bytes (up to four) as the response port takes them; a flush
// emits any partial byte. The byte-wide response port sets the sustained rate.
// Reset is synchronous and clears the table's valid bits, the pending bits, the
// queue and the response register; no clearing pass is needed.
// Either side may stall: the queue and the response register decouple them.
module huffman_table_encoder_packer import hte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] symbol, [39:8] code_value, [45:40] code_length, [47:46] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  logic [OPCODE_W-1:0]   req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] out_byte
   output logic [BYTE_BITS-1:0]  rsp_tdata,
   output logic                  rsp_tlast
);

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop;
   cmd_type pop_cmd;

   // Front: decodes requests, owns the code table, looks up encode symbols
   hte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   // Encode/flush commands waiting for the packer
   hte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   // Back: bit accumulator and byte emitter
   hte_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd        (pop_cmd),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
